FILE: rtl/disk_block_allocation_table_core_macros.svh
// Assertion macros of the allocation table RTL, used by the table controller.
// Users must provide clk_i and rst_ni in the scope of each use.
`ifndef DISK_BLOCK_ALLOCATION_TABLE_CORE_MACROS_SVH
`define DISK_BLOCK_ALLOCATION_TABLE_CORE_MACROS_SVH

// A property that must hold on every clock edge out of reset.
`define DBAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that forces another one in the following cycle.
`define DBAT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/dbat_pkg.sv
// Types and constants of the disk block allocation table.
// No dependencies; used by the control module and the top level.
package dbat_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths.
  localparam int unsigned ID_W     = 32;
  localparam int unsigned SECTOR_W = 10;
  localparam int unsigned MATCH_W  = 11;
  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LIM_CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_COUNT  = 2'd3;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID    = 2'd1;

  // Reset values of the configuration.
  localparam logic [LIMIT_W-1:0] TABLE_LIMIT_RST = 11'd1024;
  localparam logic [ID_W-1:0]    FIRST_ID_RST    = 32'd1;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] path_id;
    logic [ID_W-1:0] block_number;
    logic [ID_W-1:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [ID_W-1:0]     block_id;
    logic [SECTOR_W-1:0] sector;
    logic [MATCH_W-1:0]  match_count;
  } out_item_t;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] path;
    logic [ID_W-1:0] blk;
    logic            valid;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Control from the register file to the table controller.
  typedef struct packed {
    logic [LIMIT_W-1:0] table_limit;
    logic               id_load;
    logic [ID_W-1:0]    id_value;
  } cfg_ctl_t;

  // Access request from the controller to the entry memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

FILE: rtl/disk_block_allocation_table_core.sv
// A fresh allocate writes its entry directly; every other request scans the n entries
// in use, at most TABLE_DEPTH of them, one entry a cycle.
// One item at a time: a new input is taken only once the last result has been loaded
// into the output register.
// Reset clears the used count, sets the next id to 1 and the limit to 1024;
// entries need no clearing pass, since scans only cover entries already written.
module disk_block_allocation_table_core import dbat_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ID_W-1:0]      cfg_data_i
);

  logic [LIMIT_W-1:0] table_limit_q, table_limit_d;
  cfg_ctl_t           cfg;
  ram_req_t           ram_req;
  entry_t             ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    table_limit_d = table_limit_q;
    if (cfg_valid_i && (cfg_index_i == CFG_TABLE_LIMIT)) begin
      table_limit_d = cfg_data_i[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_limit_q <= TABLE_LIMIT_RST;
    end else begin
      table_limit_q <= table_limit_d;
    end
  end

  assign cfg.table_limit = table_limit_q;
  assign cfg.id_load     = cfg_valid_i && (cfg_index_i == CFG_FIRST_ID);
  assign cfg.id_value    = cfg_data_i;

  // Sequencer for the operations.
  dbat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_i       (cfg),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Entry memory: id, path, block number and valid mark per sector.
  dbat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

endmodule

FILE: rtl/dbat_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dbat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with a registered output.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dbat_ctrl.sv
// Table controller: sequences fresh allocation and the linear table scans.
// Depends on dbat_pkg and drives the entry memory through a ram_req_t.
`include "disk_block_allocation_table_core_macros.svh"

module dbat_ctrl import dbat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  cfg_ctl_t  cfg_i,
  output ram_req_t  ram_req_o,
  input  entry_t    ram_rdata_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_START  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              eval_vld_q, eval_vld_d;
  logic [ADDR_W-1:0] eval_idx_q, eval_idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  in_item_t          item_q, item_d;
  out_item_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [LIM_CMP_W-1:0] lim_eff;
  logic                 fresh;
  logic                 hit;
  logic                 path_eq;
  logic                 out_load;

  // Limit in effect is the register clipped to the table depth.
  always_comb begin
    if (LIM_CMP_W'(cfg_i.table_limit) > LIM_CMP_W'(TABLE_DEPTH)) begin
      lim_eff = LIM_CMP_W'(TABLE_DEPTH);
    end else begin
      lim_eff = LIM_CMP_W'(cfg_i.table_limit);
    end
  end

  assign fresh = (item_q.operation == OP_ALLOC) && (LIM_CMP_W'(used_q) < lim_eff);

  // Match test on the entry that the memory returns this cycle.
  assign path_eq = (ram_rdata_i.path == item_q.path_id);
  always_comb begin
    unique case (item_q.operation)
      OP_ALLOC:  hit = !ram_rdata_i.valid;
      OP_LOOKUP: hit = ram_rdata_i.valid && path_eq &&
                       (ram_rdata_i.blk == item_q.block_number);
      OP_FREE:   hit = (ram_rdata_i.id == item_q.target_id);
      OP_COUNT:  hit = 1'b0;
    endcase
  end

  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // Sequencer: start, scan one entry per cycle unless a fresh allocate applies, then hand the result over.
  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    next_id_d  = next_id_q;
    rd_idx_d   = rd_idx_q;
    eval_vld_d = 1'b0;
    eval_idx_d = eval_idx_q;
    cnt_d      = cnt_q;
    item_d     = item_q;
    res_d      = res_q;
    ram_req_o  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (fresh) begin
          ram_req_o.we          = 1'b1;
          ram_req_o.waddr       = used_q[ADDR_W-1:0];
          ram_req_o.wdata.id    = next_id_q;
          ram_req_o.wdata.path  = item_q.path_id;
          ram_req_o.wdata.blk   = item_q.block_number;
          ram_req_o.wdata.valid = 1'b1;
          res_d.status      = STATUS_OK;
          res_d.block_id    = next_id_q;
          res_d.sector      = SECTOR_W'(used_q[ADDR_W-1:0]);
          res_d.match_count = '0;
          next_id_d = next_id_q + 1'b1;
          used_d    = used_q + 1'b1;
          state_d   = ST_FINISH;
        end else begin
          rd_idx_d = '0;
          cnt_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (eval_vld_q && hit) begin
          // First hit ends the scan; allocate and free write the entry back.
          ram_req_o.we          = (item_q.operation == OP_ALLOC) ||
                                  (item_q.operation == OP_FREE);
          ram_req_o.waddr       = eval_idx_q;
          ram_req_o.wdata.id    = ram_rdata_i.id;
          ram_req_o.wdata.path  = (item_q.operation == OP_ALLOC) ?
                                  item_q.path_id : ram_rdata_i.path;
          ram_req_o.wdata.blk   = (item_q.operation == OP_ALLOC) ?
                                  item_q.block_number : ram_rdata_i.blk;
          ram_req_o.wdata.valid = (item_q.operation == OP_ALLOC);
          res_d.status      = STATUS_OK;
          res_d.block_id    = ram_rdata_i.id;
          res_d.sector      = SECTOR_W'(eval_idx_q);
          res_d.match_count = '0;
          state_d = ST_FINISH;
        end else if (!eval_vld_q && (rd_idx_q >= used_q)) begin
          // Every entry in use has been seen without a hit.
          res_d.status      = (item_q.operation == OP_COUNT) ? STATUS_OK : STATUS_FAIL;
          res_d.block_id    = '0;
          res_d.sector      = '0;
          res_d.match_count = (item_q.operation == OP_COUNT) ? MATCH_W'(cnt_q) : '0;
          state_d = ST_FINISH;
        end else begin
          if (eval_vld_q && path_eq) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (rd_idx_q < used_q) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = rd_idx_q[ADDR_W-1:0];
            rd_idx_d        = rd_idx_q + 1'b1;
            eval_vld_d      = 1'b1;
            eval_idx_d      = rd_idx_q[ADDR_W-1:0];
          end
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
    endcase

    // A write of first_id restarts the id sequence.
    if (cfg_i.id_load) begin
      next_id_d = cfg_i.id_value;
    end
  end

  // Output register decouples the result from the next transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      next_id_q   <= FIRST_ID_RST;
      eval_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      item_q      <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      next_id_q   <= next_id_d;
      eval_vld_q  <= eval_vld_d;
      out_valid_q <= out_valid_d;
      item_q      <= item_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    eval_idx_q <= eval_idx_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `DBAT_ASSERT(a_used_in_range, used_q <= CNT_W'(TABLE_DEPTH), "used count beyond table depth")
  `DBAT_ASSERT(a_write_when_busy, !ram_req_o.we || state_q == ST_START || state_q == ST_SCAN, "memory write outside an operation")
  `DBAT_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == ST_START, "accepted item did not start")
  `DBAT_ASSERT(a_scan_bounded, state_q != ST_SCAN || rd_idx_q <= used_q, "scan ran past the entries in use")

endmodule

FILE: tb/tb_dbat_checker.sv
`timescale 1ns / 100ps
// Checker for the disk block allocation table: watches the request, result and
// register channels, keeps its own copy of the table and compares each result.
// Depends on dbat_pkg for the payload types, operation codes and register indexes.
module dbat_table_checker import dbat_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ID_W-1:0]      cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  // Shadow copy of the table and its registers.
  bit [ID_W-1:0]    shadow_id    [TABLE_DEPTH];
  bit [ID_W-1:0]    shadow_path  [TABLE_DEPTH];
  bit [ID_W-1:0]    shadow_blk   [TABLE_DEPTH];
  bit               shadow_valid [TABLE_DEPTH];
  int unsigned      entries_used;
  bit [LIMIT_W-1:0] limit_reg;
  bit [ID_W-1:0]    id_seq;

  out_item_t   expected_replies[$];
  int unsigned mismatches = 0;
  int unsigned waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  // Applies one request to the shadow table and returns the result it must give.
  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t   res;
    int unsigned lim;
    int unsigned hits;
    bit          found;
    res = '0;
    res.status = STATUS_FAIL;
    found = 1'b0;
    hits = 0;
    lim = (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
    case (req.operation)
      OP_ALLOC: begin
        if (entries_used < lim) begin
          // Append a fresh entry with the next id of the sequence.
          shadow_id[entries_used]    = id_seq;
          shadow_path[entries_used]  = req.path_id;
          shadow_blk[entries_used]   = req.block_number;
          shadow_valid[entries_used] = 1'b1;
          res.status   = STATUS_OK;
          res.block_id = id_seq;
          res.sector   = SECTOR_W'(entries_used);
          id_seq       = id_seq + 1;
          entries_used = entries_used + 1;
        end else begin
          // Reuse the first freed entry; it keeps its old id.
          for (int i = 0; i < entries_used && !found; i++) begin
            if (!shadow_valid[i]) begin
              shadow_path[i]  = req.path_id;
              shadow_blk[i]   = req.block_number;
              shadow_valid[i] = 1'b1;
              res.status   = STATUS_OK;
              res.block_id = shadow_id[i];
              res.sector   = SECTOR_W'(i);
              found = 1'b1;
            end
          end
        end
      end
      OP_LOOKUP: begin
        for (int i = 0; i < entries_used && !found; i++) begin
          if (shadow_valid[i] && shadow_path[i] == req.path_id &&
              shadow_blk[i] == req.block_number) begin
            res.status   = STATUS_OK;
            res.block_id = shadow_id[i];
            res.sector   = SECTOR_W'(i);
            found = 1'b1;
          end
        end
      end
      OP_FREE: begin
        // The first entry with the id is freed even when it is already free.
        for (int i = 0; i < entries_used && !found; i++) begin
          if (shadow_id[i] == req.target_id) begin
            shadow_valid[i] = 1'b0;
            res.status   = STATUS_OK;
            res.block_id = shadow_id[i];
            res.sector   = SECTOR_W'(i);
            found = 1'b1;
          end
        end
      end
      OP_COUNT: begin
        // Freed entries still count.
        for (int i = 0; i < entries_used; i++) begin
          if (shadow_path[i] == req.path_id) hits++;
        end
        res.status      = STATUS_OK;
        res.match_count = MATCH_W'(hits);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [ID_W-1:0] exp_v,
                                      input logic [ID_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Register writes, result checks and request predictions, in that order.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      entries_used = 0;
      limit_reg    = TABLE_LIMIT_RST;
      id_seq       = FIRST_ID_RST;
      expected_replies.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TABLE_LIMIT: limit_reg = cfg_data_i[LIMIT_W-1:0];
          CFG_FIRST_ID:    id_seq = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with no request waiting: 0x%0h", out_item_i);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", ID_W'(want.status), ID_W'(out_item_i.status));
          check_field("block_id", want.block_id, out_item_i.block_id);
          check_field("sector", ID_W'(want.sector), ID_W'(out_item_i.sector));
          check_field("match_count", ID_W'(want.match_count), ID_W'(out_item_i.match_count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_replies.push_back(apply_request(in_item_i));
      end
    end
    waiting = expected_replies.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the allocation table testbench: clock, reset, request and register
// stimulus, result sink and verdict. Depends on dbat_pkg, the core and the checker.
module tb_top;
  import dbat_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam int unsigned          CYCLE_LIMIT = 5_000_000;
  localparam logic [ID_W-1:0]      ALL_ONES    = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ID_W-1:0]      cfg_data;

  int unsigned     mismatches;
  int unsigned     pending;
  int unsigned     cycle_count = 0;
  bit              no_gaps = 1'b0;
  bit              sink_hold = 1'b0;
  logic [ID_W-1:0] path_pool [8];
  logic [ID_W-1:0] id_bases[$];

  disk_block_allocation_table_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dbat_table_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (mismatches),
    .pending_o    (pending)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result sink: a random stall before each transfer, or one long hold on request.
  initial begin : result_sink
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold) begin
        sink_hold = 1'b0;
        gap = 300;
      end else if (no_gaps) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  function automatic in_item_t make_request(input logic [1:0] op, input logic [ID_W-1:0] path,
                                            input logic [ID_W-1:0] blk,
                                            input logic [ID_W-1:0] tid);
    in_item_t r;
    r.operation    = op;
    r.path_id      = path;
    r.block_number = blk;
    r.target_id    = tid;
    return r;
  endfunction

  // Mostly requests that hit the table: paths from a small pool, low block
  // numbers and ids near a sequence start; the rest is fully random.
  function automatic in_item_t random_request();
    in_item_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.operation = OP_ALLOC;
    else if (pick < 60) r.operation = OP_LOOKUP;
    else if (pick < 82) r.operation = OP_FREE;
    else                r.operation = OP_COUNT;
    r.path_id = ($urandom_range(0, 9) < 8) ? path_pool[$urandom_range(0, 7)] : $urandom();
    r.block_number = ($urandom_range(0, 9) < 8) ? ID_W'($urandom_range(0, 15)) : $urandom();
    r.target_id = ($urandom_range(0, 9) < 8) ?
                  id_bases[$urandom_range(0, id_bases.size() - 1)] + $urandom_range(0, 48) :
                  $urandom();
    return r;
  endfunction

  // One request transfer, after a random gap unless gaps are off.
  task automatic send_op(input in_item_t req);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item  <= req;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!(in_valid && in_ready));
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // A random phase under a new limit and id sequence.
  task automatic run_phase(input logic [ID_W-1:0] limit, input logic [ID_W-1:0] base,
                           input int unsigned items, input bit calm, input bit stall_sink);
    drain();
    set_config(CFG_TABLE_LIMIT, limit);
    set_config(CFG_FIRST_ID, base);
    id_bases.push_back(base);
    no_gaps   = calm;
    sink_hold = stall_sink;
    repeat (items) send_op(random_request());
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    foreach (path_pool[i]) path_pool[i] = $urandom();
    id_bases.push_back(FIRST_ID_RST);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A three-entry table whose ids wrap past the top of the range.
    set_config(CFG_TABLE_LIMIT, 32'd3);
    set_config(CFG_FIRST_ID, 32'hFFFF_FFFE);
    id_bases.push_back(32'hFFFF_FFFE);
    send_op(make_request(OP_COUNT, '0, '0, '0));
    send_op(make_request(OP_LOOKUP, ALL_ONES, ALL_ONES, '0));
    send_op(make_request(OP_FREE, '0, '0, ALL_ONES));
    send_op(make_request(OP_ALLOC, ALL_ONES, '0, '0));
    send_op(make_request(OP_ALLOC, '0, ALL_ONES, '0));
    send_op(make_request(OP_ALLOC, ALL_ONES, ALL_ONES, ALL_ONES));
    // Table full: every entry is still valid.
    send_op(make_request(OP_ALLOC, 32'd5, 32'd5, '0));
    send_op(make_request(OP_LOOKUP, ALL_ONES, ALL_ONES, '0));
    send_op(make_request(OP_LOOKUP, ALL_ONES, 32'd1, '0));
    send_op(make_request(OP_COUNT, ALL_ONES, '0, '0));
    // Free the same id twice; the second hits an entry that is already free.
    send_op(make_request(OP_FREE, '0, '0, ALL_ONES));
    send_op(make_request(OP_FREE, '0, '0, ALL_ONES));
    send_op(make_request(OP_LOOKUP, '0, ALL_ONES, '0));
    send_op(make_request(OP_COUNT, '0, '0, '0));
    send_op(make_request(OP_ALLOC, 32'h5555_AAAA, 32'hAAAA_5555, '0));
    send_op(make_request(OP_FREE, '0, '0, 32'h1234_5678));
    drain();

    // An unused register index, then a limit of zero, which only allows reuse.
    set_config(CFG_UNUSED, $urandom());
    set_config(CFG_TABLE_LIMIT, 32'd0);
    send_op(make_request(OP_ALLOC, 32'd7, 32'd7, '0));
    send_op(make_request(OP_FREE, '0, '0, 32'hFFFF_FFFE));
    send_op(make_request(OP_ALLOC, 32'd7, 32'd7, '0));
    drain();

    // A limit beyond the table depth and a restarted id sequence at zero.
    set_config(CFG_TABLE_LIMIT, 32'd2047);
    set_config(CFG_FIRST_ID, '0);
    id_bases.push_back('0);
    send_op(make_request(OP_ALLOC, 32'hAAAA_5555, 32'h5555_AAAA, '0));
    send_op(make_request(OP_FREE, '0, '0, '0));
    send_op(make_request(OP_LOOKUP, 32'h5555_AAAA, 32'hAAAA_5555, '0));
    send_op(make_request(OP_COUNT, 32'hAAAA_5555, '0, '0));

    // Random phases; the limit of one lies below the entries already in use.
    run_phase(32'd8, $urandom(), 80, 1'b0, 1'b0);
    run_phase(32'd1, $urandom(), 70, 1'b0, 1'b1);
    run_phase(32'd64, '0, 100, 1'b1, 1'b0);
    run_phase(32'd2047, 32'hFFFF_FFF0, 150, 1'b0, 1'b0);
    run_phase(32'd1024, $urandom(), 160, 1'b0, 1'b0);

    drain();
    repeat (TABLE_DEPTH + 16) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
